/* src/fbpw_pkg.sv */
// shared types, constants and helper functions of the frame buffer pixel writer
package fbpw_pkg;

  localparam int unsigned MAX_SCREEN_WIDTH = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

  // floor(c * 23 / 25) as c * 23 * ceil(2^17 / 25) >> 17
  localparam logic [24:0] SCALE_MUL = 25'd120589;
  localparam int unsigned SCALE_SHIFT = 17;

  typedef enum logic [1:0] {
    MODE_32  = 2'd0,
    MODE_24  = 2'd1,
    MODE_565 = 2'd2,
    MODE_PAL = 2'd3
  } pix_mode_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [25:0] byte_address;
    logic [7:0]  byte_data;
    logic        palette_write;
    logic [7:0]  palette_index;
    logic [15:0] palette_red;
    logic [15:0] palette_green;
    logic [15:0] palette_blue;
    logic        last_of_pixel;
    logic        last_of_image;
  } byte_out_t;

  typedef struct packed {
    logic [25:0] base_addr;
    pix_mode_t   mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        end_img;
  } qentry_t;

  function automatic logic [12:0] clamp_stride(input logic [12:0] sw);
    logic [12:0] res;
    res = (sw > 13'(MAX_SCREEN_WIDTH)) ? 13'(MAX_SCREEN_WIDTH) : sw;
    return res;
  endfunction

  function automatic logic [7:0] pal_scale(input logic [7:0] c);
    logic [24:0] p;
    p = 25'(c) * SCALE_MUL;
    return p[SCALE_SHIFT+7:SCALE_SHIFT];
  endfunction

endpackage

/* src/framebuffer_pixel_writer_top.sv */
// top level of the frame buffer pixel writer
//
// pixels come in raster order on in_valid/in_ready/in_data (red, green, blue)
// byte writes leave on out_valid/out_ready/out_data, one byte per item, with
// palette fields in 8 bit mode and last_of_pixel/last_of_image flags
// registers are written through cfg_wr_en/cfg_index/cfg_data with no wait;
// any write to one of the six defined registers restarts the image at its top left corner
// an accepted pixel is written into a four entry queue; from the queue head its bytes
// move into the output register whenever that register is empty or being taken
// the output stage sends one byte per cycle while out_ready is high and the queue holds
// pixels; a pixel gives 3 bytes in 32 and 24 bit modes, 2 in RGB565 mode and 1 in 8 bit mode
// in_ready drops only while the queue is full, so pixels are taken while
// earlier bytes still wait
// when out_ready is low the output byte holds and the queue fills, then
// in_ready goes low
// reset restores the register defaults (1024 wide screen, 32 bit mode, image
// of one pixel at the origin) and empties the queue and output register
module framebuffer_pixel_writer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fbpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fbpw_pkg::pixel_in_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fbpw_pkg::byte_out_t              out_data
);
  import fbpw_pkg::*;

  logic    q_push;
  qentry_t q_entry;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  qentry_t q_head;

  fbpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full)
  );

  fbpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  fbpw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/fbpw_front.sv */
// front end: configuration registers, raster counters and pixel classification
module fbpw_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fbpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fbpw_pkg::pixel_in_t              in_data,
  output logic                             q_push,
  output fbpw_pkg::qentry_t                q_entry,
  input  logic                             q_full
);
  import fbpw_pkg::*;

  logic [12:0] sw_r, sw_nxt;
  pix_mode_t   mode_r, mode_nxt;
  logic [11:0] dx_r, dx_nxt;
  logic [11:0] dy_r, dy_nxt;
  logic [12:0] iw_r, iw_nxt;
  logic [12:0] ih_r, ih_nxt;
  logic        cfg_hit;

  logic [11:0] col_r;
  logic [11:0] row_r;
  logic [23:0] row_base_r;
  logic [23:0] start_base_r;
  logic [23:0] start_base_nxt;
  logic [24:0] start_prod;

  logic        accept;
  logic        end_row;
  logic        end_img;
  logic [23:0] pix;
  logic [12:0] stride;

  always_comb begin
    sw_nxt   = sw_r;
    mode_nxt = mode_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    iw_nxt   = iw_r;
    ih_nxt   = ih_r;
    cfg_hit  = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH: begin
          sw_nxt  = cfg_data;
          cfg_hit = 1'b1;
        end
        CFG_PIXEL_MODE: begin
          mode_nxt = pix_mode_t'(cfg_data[1:0]);
          cfg_hit  = 1'b1;
        end
        CFG_DEST_X: begin
          dx_nxt  = cfg_data[11:0];
          cfg_hit = 1'b1;
        end
        CFG_DEST_Y: begin
          dy_nxt  = cfg_data[11:0];
          cfg_hit = 1'b1;
        end
        CFG_IMAGE_WIDTH: begin
          iw_nxt  = cfg_data;
          cfg_hit = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          ih_nxt  = cfg_data;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign start_prod     = 25'(dy_nxt) * 25'(clamp_stride(sw_nxt));
  assign start_base_nxt = start_prod[23:0] + 24'(dx_nxt);

  assign stride   = clamp_stride(sw_r);
  assign in_ready = ~q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept;

  assign pix     = row_base_r + 24'(col_r);
  assign end_row = ({1'b0, col_r} + 13'd1) >= iw_r;
  assign end_img = end_row && (({1'b0, row_r} + 13'd1) >= ih_r);

  always_comb begin
    q_entry.mode    = mode_r;
    q_entry.end_img = end_img;
    q_entry.red     = in_data.pixel_red;
    q_entry.green   = in_data.pixel_green;
    q_entry.blue    = in_data.pixel_blue;
    unique case (mode_r)
      MODE_32:  q_entry.base_addr = {pix, 2'b00};
      MODE_24:  q_entry.base_addr = {1'b0, pix, 1'b0} + {2'b00, pix};
      MODE_565: q_entry.base_addr = {1'b0, pix, 1'b0};
      MODE_PAL: begin
        q_entry.base_addr = {2'b00, pix};
        q_entry.red       = pal_scale(in_data.pixel_red);
        q_entry.green     = pal_scale(in_data.pixel_green);
        q_entry.blue      = pal_scale(in_data.pixel_blue);
      end
      default:  q_entry.base_addr = {2'b00, pix};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r         <= 13'd1024;
      mode_r       <= MODE_32;
      dx_r         <= '0;
      dy_r         <= '0;
      iw_r         <= 13'd1;
      ih_r         <= 13'd1;
      col_r        <= '0;
      row_r        <= '0;
      row_base_r   <= '0;
      start_base_r <= '0;
    end else begin
      sw_r   <= sw_nxt;
      mode_r <= mode_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      iw_r   <= iw_nxt;
      ih_r   <= ih_nxt;
      if (cfg_hit) begin
        col_r        <= '0;
        row_r        <= '0;
        row_base_r   <= start_base_nxt;
        start_base_r <= start_base_nxt;
      end else if (accept) begin
        priority if (end_img) begin
          col_r      <= '0;
          row_r      <= '0;
          row_base_r <= start_base_r;
        end else if (end_row) begin
          col_r      <= '0;
          row_r      <= row_r + 12'd1;
          row_base_r <= row_base_r + 24'(stride);
        end else begin
          col_r <= col_r + 12'd1;
        end
      end
    end
  end

endmodule

/* src/fbpw_queue.sv */
// short queue of classified pixels between front and back end
module fbpw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fbpw_pkg::qentry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output fbpw_pkg::qentry_t  head_entry
);
  import fbpw_pkg::*;

  qentry_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* src/fbpw_back.sv */
// back end: splits each queued pixel into byte writes through an output register
module fbpw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fbpw_pkg::qentry_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output fbpw_pkg::byte_out_t out_data
);
  import fbpw_pkg::*;

  logic [1:0] k_r;
  logic [1:0] last_k;
  logic       last_byte;
  logic       advance;
  logic       out_valid_r;
  byte_out_t  out_data_r;
  byte_out_t  byte_nxt;

  always_comb begin
    unique case (q_head.mode)
      MODE_32, MODE_24: last_k = 2'd2;
      MODE_565:         last_k = 2'd1;
      MODE_PAL:         last_k = 2'd0;
      default:          last_k = 2'd0;
    endcase
  end

  assign last_byte = (k_r == last_k);
  assign advance   = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = advance && last_byte;

  always_comb begin
    byte_nxt               = '0;
    byte_nxt.byte_address  = q_head.base_addr + 26'(k_r);
    byte_nxt.last_of_pixel = last_byte;
    byte_nxt.last_of_image = last_byte & q_head.end_img;
    unique case (q_head.mode)
      MODE_32, MODE_24: begin
        unique case (k_r)
          2'd0:    byte_nxt.byte_data = q_head.blue;
          2'd1:    byte_nxt.byte_data = q_head.green;
          default: byte_nxt.byte_data = q_head.red;
        endcase
      end
      MODE_565: begin
        if (k_r == 2'd0) begin
          byte_nxt.byte_data = {q_head.green[4:2], q_head.blue[7:3]};
        end else begin
          byte_nxt.byte_data = {q_head.red[7:3], q_head.green[7:5]};
        end
      end
      MODE_PAL: begin
        byte_nxt.byte_data     = {q_head.red[7:6], q_head.green[7:4], q_head.blue[7:6]};
        byte_nxt.palette_write = 1'b1;
        byte_nxt.palette_index = byte_nxt.byte_data;
        byte_nxt.palette_red   = {q_head.red, 8'h00};
        byte_nxt.palette_green = {q_head.green, 8'h00};
        byte_nxt.palette_blue  = {q_head.blue, 8'h00};
      end
      default: byte_nxt.byte_data = q_head.blue;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        k_r         <= last_byte ? 2'd0 : k_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/framebuffer_pixel_writer_top_test.sv */
// self-checking testbench of the frame buffer pixel writer: random pixels, settings and idling
module framebuffer_pixel_writer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_PIXELS = 430;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  byte_out_t             out_data;

  framebuffer_pixel_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers and raster position
  logic [12:0] reg_screen_width;
  pix_mode_t   reg_mode;
  logic [11:0] reg_dest_x;
  logic [11:0] reg_dest_y;
  logic [12:0] reg_image_width;
  logic [12:0] reg_image_height;
  logic [11:0] col_cnt;
  logic [11:0] row_cnt;
  logic [23:0] row_base;

  pixel_in_t   pixels_pending[$];
  byte_out_t   byte_writes_due[$];
  byte_out_t   due_write;

  bit          steady_flow;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned pixels_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned palette_writes = 0;
  int unsigned images_done = 0;
  int unsigned settings_count = 0;
  int unsigned random_pixels = 0;
  int unsigned n_pix;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] val;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (steady_flow || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned row_stride();
    return (reg_screen_width > MAX_SCREEN_WIDTH) ? MAX_SCREEN_WIDTH : int'(reg_screen_width);
  endfunction

  task automatic restart_image();
    col_cnt = '0;
    row_cnt = '0;
    row_base = 24'(int'(reg_dest_y) * row_stride() + int'(reg_dest_x));
  endtask

  task automatic predict_byte_writes(input pixel_in_t px);
    logic [23:0] pix;
    logic [25:0] addr;
    logic [7:0]  sr, sg, sb;
    bit          end_row, end_img;
    byte_out_t   w;
    pix = row_base + 24'(col_cnt);
    end_row = (int'(col_cnt) + 1 >= int'(reg_image_width));
    end_img = end_row && (int'(row_cnt) + 1 >= int'(reg_image_height));
    w = '0;
    case (reg_mode)
      MODE_32, MODE_24: begin
        addr = (reg_mode == MODE_32) ? {pix, 2'b00} : 26'(pix) * 26'd3;
        w.byte_address = addr;
        w.byte_data = px.pixel_blue;
        byte_writes_due.push_back(w);
        w.byte_address = addr + 26'd1;
        w.byte_data = px.pixel_green;
        byte_writes_due.push_back(w);
        w.byte_address = addr + 26'd2;
        w.byte_data = px.pixel_red;
        w.last_of_pixel = 1'b1;
        w.last_of_image = end_img;
        byte_writes_due.push_back(w);
      end
      MODE_565: begin
        addr = {1'b0, pix, 1'b0};
        w.byte_address = addr;
        w.byte_data = {px.pixel_green[4:2], px.pixel_blue[7:3]};
        byte_writes_due.push_back(w);
        w.byte_address = addr + 26'd1;
        w.byte_data = {px.pixel_red[7:3], px.pixel_green[7:5]};
        w.last_of_pixel = 1'b1;
        w.last_of_image = end_img;
        byte_writes_due.push_back(w);
      end
      default: begin
        sr = 8'((int'(px.pixel_red) * 23) / 25);
        sg = 8'((int'(px.pixel_green) * 23) / 25);
        sb = 8'((int'(px.pixel_blue) * 23) / 25);
        w.byte_address = 26'(pix);
        w.byte_data = {sr[7:6], sg[7:4], sb[7:6]};
        w.palette_write = 1'b1;
        w.palette_index = w.byte_data;
        w.palette_red = {sr, 8'h00};
        w.palette_green = {sg, 8'h00};
        w.palette_blue = {sb, 8'h00};
        w.last_of_pixel = 1'b1;
        w.last_of_image = end_img;
        byte_writes_due.push_back(w);
      end
    endcase
    if (end_img) begin
      restart_image();
    end else if (end_row) begin
      col_cnt = '0;
      row_cnt = row_cnt + 12'd1;
      row_base = row_base + 24'(row_stride());
    end else begin
      col_cnt = col_cnt + 12'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    $display("mismatch at byte %0d: %s got 0x%0h expected 0x%0h",
             bytes_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] rv);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= ri;
    cfg_data <= rv;
    case (ri)
      CFG_SCREEN_WIDTH: reg_screen_width = rv;
      CFG_PIXEL_MODE:   reg_mode = pix_mode_t'(rv[1:0]);
      CFG_DEST_X:       reg_dest_x = rv[11:0];
      CFG_DEST_Y:       reg_dest_y = rv[11:0];
      CFG_IMAGE_WIDTH:  reg_image_width = rv;
      CFG_IMAGE_HEIGHT: reg_image_height = rv;
      default: ;
    endcase
    if (ri <= CFG_IMAGE_HEIGHT) restart_image();
  endtask

  task automatic cfg_end();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixels_pending.push_back('{pixel_red: r, pixel_green: g, pixel_blue: b});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_pending.size() != 0 || in_valid || byte_writes_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte_writes(in_data);
        pixels_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixels_pending.size() != 0) begin
          in_data <= pixels_pending.pop_front();
          in_valid <= 1'b1;
          in_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte write monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (byte_writes_due.size() == 0) begin
          report_mismatch("byte write with none expected, address", out_data.byte_address, 0);
        end else begin
          due_write = byte_writes_due.pop_front();
          check_field("byte_address", out_data.byte_address, due_write.byte_address);
          check_field("byte_data", out_data.byte_data, due_write.byte_data);
          check_field("palette_write", out_data.palette_write, due_write.palette_write);
          check_field("palette_index", out_data.palette_index, due_write.palette_index);
          check_field("palette_red", out_data.palette_red, due_write.palette_red);
          check_field("palette_green", out_data.palette_green, due_write.palette_green);
          check_field("palette_blue", out_data.palette_blue, due_write.palette_blue);
          check_field("last_of_pixel", out_data.last_of_pixel, due_write.last_of_pixel);
          check_field("last_of_image", out_data.last_of_image, due_write.last_of_image);
        end
        bytes_checked++;
        if (out_data.palette_write) palette_writes++;
        if (out_data.last_of_image) images_done++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_gap = gap_len();
        out_ready <= (out_gap == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d byte writes outstanding",
               cycle_count, byte_writes_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    reg_screen_width = 13'd1024;
    reg_mode = MODE_32;
    reg_dest_x = '0;
    reg_dest_y = '0;
    reg_image_width = 13'd1;
    reg_image_height = 13'd1;
    restart_image();
    steady_flow = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults, channel extremes
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    wait_drained();

    // 24 bit, saturated stride, base at the top of the 24 bit range
    steady_flow = 1'b0;
    cfg_write(CFG_PIXEL_MODE, 13'(MODE_24));
    cfg_write(CFG_SCREEN_WIDTH, 13'd8191);
    cfg_write(CFG_DEST_X, 13'd4095);
    cfg_write(CFG_DEST_Y, 13'd4095);
    cfg_write(CFG_IMAGE_WIDTH, 13'd2);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd2);
    cfg_end();
    push_pixel(8'h80, 8'h01, 8'hfe);
    push_pixel(8'h7f, 8'haa, 8'h55);
    push_pixel(8'h12, 8'h34, 8'h56);
    wait_drained();
    // spare indexes must leave the raster position alone
    cfg_write(CFG_SPARE_HI, 13'h1fff);
    cfg_write(CFG_SPARE_LO, 13'h0aaa);
    cfg_end();
    push_pixel(8'hc3, 8'h3c, 8'h99);
    push_pixel(8'h01, 8'h80, 8'h10);
    wait_drained();

    // rgb565 with zero stride, restart mid image
    cfg_write(CFG_PIXEL_MODE, 13'(MODE_565));
    cfg_write(CFG_SCREEN_WIDTH, 13'd0);
    cfg_write(CFG_DEST_X, 13'd7);
    cfg_write(CFG_IMAGE_WIDTH, 13'd3);
    cfg_end();
    push_pixel(8'hff, 8'h00, 8'hff);
    push_pixel(8'h00, 8'hff, 8'h00);
    push_pixel(8'h07, 8'h1c, 8'h07);
    push_pixel(8'hf8, 8'he3, 8'hf8);
    wait_drained();

    // palette mode, zero image size, image beyond the screen edge
    cfg_write(CFG_PIXEL_MODE, 13'(MODE_PAL));
    cfg_write(CFG_SCREEN_WIDTH, 13'd16);
    cfg_write(CFG_DEST_X, 13'd4095);
    cfg_write(CFG_DEST_Y, 13'd7);
    cfg_write(CFG_IMAGE_WIDTH, 13'd0);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd0);
    cfg_end();
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'd25, 8'd26, 8'd24);
    push_pixel(8'd128, 8'd64, 8'd200);
    wait_drained();

    // 32 bit row, moved mid row
    cfg_write(CFG_PIXEL_MODE, 13'(MODE_32));
    cfg_write(CFG_SCREEN_WIDTH, 13'd4096);
    cfg_write(CFG_IMAGE_WIDTH, 13'd5);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd1);
    cfg_end();
    push_pixel(8'h11, 8'h22, 8'h33);
    push_pixel(8'h44, 8'h55, 8'h66);
    push_pixel(8'h77, 8'h88, 8'h99);
    wait_drained();
    cfg_write(CFG_DEST_X, 13'd1);
    cfg_end();
    push_pixel(8'haa, 8'hbb, 8'hcc);
    push_pixel(8'hdd, 8'hee, 8'hff);
    push_pixel(8'h5a, 8'ha5, 8'h0f);
    wait_drained();

    while (random_pixels < RANDOM_PIXELS) begin
      steady_flow = ($urandom_range(3) == 0);
      for (int r = 0; r <= int'(CFG_IMAGE_HEIGHT); r++) begin
        if ($urandom_range(1) == 0) continue;
        idx = 3'(r);
        case (idx)
          CFG_SCREEN_WIDTH:
            case ($urandom_range(7))
              0: val = 13'd0;
              1: val = 13'd4096;
              2: val = 13'd8191;
              3: val = 13'($urandom_range(8191, 4097));
              4: val = 13'd1;
              5: val = 13'($urandom_range(4096, 1));
              default: val = 13'($urandom_range(64, 16));
            endcase
          CFG_DEST_X, CFG_DEST_Y:
            case ($urandom_range(5))
              0: val = 13'd0;
              1: val = 13'd4095;
              2: val = 13'($urandom);
              default: val = 13'($urandom_range(100));
            endcase
          CFG_IMAGE_WIDTH:
            case ($urandom_range(15))
              0: val = 13'd0;
              1: val = 13'd4096;
              2: val = 13'd8191;
              3: val = 13'($urandom_range(64, 9));
              default: val = 13'($urandom_range(8, 1));
            endcase
          CFG_IMAGE_HEIGHT:
            case ($urandom_range(11))
              0: val = 13'd0;
              1: val = 13'd8191;
              default: val = 13'($urandom_range(5, 1));
            endcase
          default: val = 13'($urandom);
        endcase
        cfg_write(idx, val);
      end
      if ($urandom_range(9) == 0)
        cfg_write($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 13'($urandom));
      cfg_end();
      n_pix = $urandom_range(40, 6);
      repeat (n_pix) push_pixel(pick_channel(), pick_channel(), pick_channel());
      random_pixels += n_pix;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d pixels over %0d register settings in all four pixel modes",
             pixels_taken, settings_count);
    $display("checked %0d byte writes, %0d with palette data, %0d images completed",
             bytes_checked, palette_writes, images_done);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
